@@ rtl/sliding_hann_power_spectrum_macros.svh @@
// assertion helpers for the sliding power spectrum block
`ifndef SLIDING_HANN_POWER_SPECTRUM_MACROS_SVH
`define SLIDING_HANN_POWER_SPECTRUM_MACROS_SVH

// condition holds in the same cycle
`define SHPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shps check failed");

// condition holds in the next cycle
`define SHPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shps check failed");

`endif

@@ rtl/shps_pkg.sv @@
package shps_pkg;

  localparam int Points   = 64;
  localparam int AddrW    = 6;
  localparam int CntW     = 7;
  localparam int HalfPts  = Points / 2;
  localparam int HannDen  = Points - 1;
  localparam int HannHalf = (Points - 1) / 2;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned OneQ30    = 64'd1073741824;

  typedef logic        [17:0] hann_t;
  typedef logic signed [18:0] twid_t;
  typedef hann_t hann_tab_t [Points];
  typedef twid_t twid_tab_t [Points];

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_SPEC  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLR, OP_WIN, OP_COS, OP_SIN, OP_ACC,
    OP_MAG, OP_SQR_R, OP_SQR_I, OP_SUM
  } mac_op_e;

  typedef struct packed {
    mac_op_e op;
    logic    dbl;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } sc_t;

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > longint'(OneQ30)) return longint'(OneQ30);
    return v;
  endfunction

  // taylor series on a quarter turn, angle and results in q30
  function automatic sc_t quarter_sincos(longint unsigned a);
    longint unsigned x2;
    longint unsigned tc [10];
    longint unsigned ts [10];
    longint cs;
    longint sn;
    sc_t r;
    x2 = (a * a) >> 30;
    tc[0] = OneQ30;
    ts[0] = a;
    tc[1] = ((tc[0] * x2) >> 30) / 2;
    tc[2] = ((tc[1] * x2) >> 30) / 12;
    tc[3] = ((tc[2] * x2) >> 30) / 30;
    tc[4] = ((tc[3] * x2) >> 30) / 56;
    tc[5] = ((tc[4] * x2) >> 30) / 90;
    tc[6] = ((tc[5] * x2) >> 30) / 132;
    tc[7] = ((tc[6] * x2) >> 30) / 182;
    tc[8] = ((tc[7] * x2) >> 30) / 240;
    tc[9] = ((tc[8] * x2) >> 30) / 306;
    ts[1] = ((ts[0] * x2) >> 30) / 6;
    ts[2] = ((ts[1] * x2) >> 30) / 20;
    ts[3] = ((ts[2] * x2) >> 30) / 42;
    ts[4] = ((ts[3] * x2) >> 30) / 72;
    ts[5] = ((ts[4] * x2) >> 30) / 110;
    ts[6] = ((ts[5] * x2) >> 30) / 156;
    ts[7] = ((ts[6] * x2) >> 30) / 210;
    ts[8] = ((ts[7] * x2) >> 30) / 272;
    ts[9] = ((ts[8] * x2) >> 30) / 342;
    cs = 0;
    sn = 0;
    for (int n = 0; n < 10; n++) begin
      if ((n % 2) == 0) begin
        cs = cs + longint'(tc[n]);
        sn = sn + longint'(ts[n]);
      end else begin
        cs = cs - longint'(tc[n]);
        sn = sn - longint'(ts[n]);
      end
    end
    r.c = clamp_unit(cs);
    r.s = clamp_unit(sn);
    return r;
  endfunction

  // cos and sin of a full-turn fraction, denominator picked by the flag
  function automatic sc_t turn_sincos(int k, bit hann_den);
    longint unsigned k4;
    longint unsigned q;
    longint unsigned rr;
    longint unsigned a;
    sc_t qv;
    sc_t r;
    k4 = 4 * longint'(k);
    if (hann_den) begin
      q  = k4 / HannDen;
      rr = k4 - q * HannDen;
      a  = (rr * HalfPiQ30) / HannDen;
    end else begin
      q  = k4 / Points;
      rr = k4 - q * Points;
      a  = (rr * HalfPiQ30) / Points;
    end
    qv = quarter_sincos(a);
    unique case (q[1:0])
      2'd0: begin r.c = qv.c;  r.s = qv.s;  end
      2'd1: begin r.c = -qv.s; r.s = qv.c;  end
      2'd2: begin r.c = -qv.c; r.s = -qv.s; end
      default: begin r.c = qv.s; r.s = -qv.c; end
    endcase
    return r;
  endfunction

  function automatic twid_t q30_to_q17(longint v);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r   = (mag + 4096) >>> 13;
    return (v < 0) ? 19'(-r) : 19'(r);
  endfunction

  function automatic hann_tab_t gen_hann();
    hann_tab_t t;
    sc_t sc;
    longint h;
    for (int i = 0; i < Points; i++) t[i] = '0;
    for (int i = 0; i <= HannHalf; i++) begin
      sc = turn_sincos(i, 1'b1);
      h  = (longint'(OneQ30) - sc.c + 8192) >>> 14;
      t[i] = 18'(h);
      t[Points-1-i] = 18'(h);
    end
    return t;
  endfunction

  function automatic twid_tab_t gen_twid(bit sine);
    twid_tab_t t;
    sc_t sc;
    for (int i = 0; i < Points; i++) begin
      sc = turn_sincos(i, 1'b0);
      t[i] = sine ? q30_to_q17(sc.s) : q30_to_q17(sc.c);
    end
    return t;
  endfunction

  localparam hann_tab_t HannTab = gen_hann();
  localparam twid_tab_t CosTab  = gen_twid(1'b0);
  localparam twid_tab_t SinTab  = gen_twid(1'b1);

endpackage

@@ rtl/shps_mac.sv @@
module shps_mac (
  input  logic                  clk_i,
  input  shps_pkg::mac_ctrl_t   ctrl_i,
  input  logic signed [15:0]    sample_i,
  input  shps_pkg::hann_t       hann_i,
  input  shps_pkg::twid_t       twc_i,
  input  shps_pkg::twid_t       tws_i,
  output logic [31:0]           power_o
);
  import shps_pkg::*;

  logic signed [35:0] op_a;
  logic signed [31:0] op_b;
  logic signed [67:0] prod;
  logic signed [63:0] prod_q;
  logic signed [33:0] x_q;
  logic signed [57:0] re_q;
  logic signed [57:0] im_q;
  logic [30:0]        mr_q;
  logic [30:0]        mi_q;
  logic [63:0]        sum_q;
  logic [57:0]        re_mag;
  logic [57:0]        im_mag;
  logic [63:0]        num;
  logic [63:0]        rnd;

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctrl_i.op)
      OP_WIN: begin
        op_a = 36'(sample_i);
        op_b = signed'({14'd0, hann_i});
      end
      OP_COS: begin
        op_a = prod_q[35:0];
        op_b = 32'(twc_i);
      end
      OP_SIN: begin
        op_a = 36'(x_q);
        op_b = 32'(tws_i);
      end
      OP_SQR_R: begin
        op_a = signed'({5'd0, mr_q});
        op_b = signed'({1'b0, mr_q});
      end
      OP_SQR_I: begin
        op_a = signed'({5'd0, mi_q});
        op_b = signed'({1'b0, mi_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod   = op_a * op_b;
  assign re_mag = re_q[57] ? 58'(-re_q) : 58'(re_q);
  assign im_mag = im_q[57] ? 58'(-im_q) : 58'(im_q);

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_CLR: begin
        re_q <= '0;
        im_q <= '0;
      end
      OP_WIN: prod_q <= prod[63:0];
      OP_COS: begin
        x_q    <= prod_q[33:0];
        prod_q <= prod[63:0];
      end
      OP_SIN: begin
        re_q   <= re_q + prod_q[57:0];
        prod_q <= prod[63:0];
      end
      OP_ACC: im_q <= im_q + prod_q[57:0];
      OP_MAG: begin
        mr_q <= 31'((re_mag + 58'd16777216) >> 25);
        mi_q <= 31'((im_mag + 58'd16777216) >> 25);
      end
      OP_SQR_R: prod_q <= prod[63:0];
      OP_SQR_I: begin
        sum_q  <= prod_q;
        prod_q <= prod[63:0];
      end
      OP_SUM: sum_q <= sum_q + prod_q;
      default: ;
    endcase
  end

  // scale by 1/points^2 into q2.30, round half up, saturate
  assign num     = ctrl_i.dbl ? {sum_q[62:0], 1'b0} : sum_q;
  assign rnd     = (num + 64'd536870912) >> 30;
  assign power_o = (rnd[63:32] != '0) ? 32'hFFFF_FFFF : rnd[31:0];

endmodule

@@ rtl/sliding_hann_power_spectrum.sv @@
// sliding hann-windowed power spectrum
// input channel (in_valid_i / in_ready_o) carries one item with mode_i and
// sample_i: mode add pushes sample_i into a ring of the newest 64 samples,
// mode clear empties the ring, mode spectrum asks for the power of bins
// 0..32 of the hann-windowed window, oldest sample first; mode 3 is dropped.
// output channel (out_valid_o / out_ready_i) carries one item per bin with
// bin_o, power_o (unsigned q2.30), ready_res_o and last_o on bin 32.
// a request that finds fewer than 64 samples gives one item with bin 0,
// power 0, ready_res_o low and last_o high, registered from the emit state.
// add, clear and dropped items leave in_ready_o high. a spectrum request
// runs each bin on the single shared multiplier: clear, then read, window,
// cosine, sine and accumulate for each of the 64 samples, then magnitude,
// two squares, sum and emit, for all 33 bins; in_ready_o stays low until
// the last bin is emitted. results sit in an output register; if the
// receiver stalls, the sequencer waits before loading the next bin.
// reset empties the ring and idles the sequencer; ring contents are not
// cleared and are never read before the ring is full.
module sliding_hann_power_spectrum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         bin_o,
  output logic [31:0]        power_o,
  output logic               ready_res_o,
  output logic               last_o
);
  import shps_pkg::*;
  `include "sliding_hann_power_spectrum_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_BIN, ST_RD, ST_WIN, ST_COS, ST_SIN, ST_ACC,
    ST_MAG, ST_SQR_R, ST_SQR_I, ST_SUM, ST_EMIT
  } state_e;

  state_e            state_q;
  logic [AddrW-1:0]  wp_q;
  logic [CntW-1:0]   fill_q;
  logic [AddrW-1:0]  i_q;
  logic [AddrW-1:0]  idx_q;
  logic [AddrW-1:0]  k_q;
  logic              nr_q;
  logic              out_valid_q;
  logic [5:0]        bin_q;
  logic [31:0]       power_q;
  logic              rdy_res_q;
  logic              last_q;

  // sample ring, registered read
  logic signed [15:0] ring_mem [Points];
  logic signed [15:0] rd_q;
  logic [AddrW-1:0]   rd_addr;

  logic       in_acc;
  logic       out_free;
  logic       emit_fire;
  mode_e      mode;
  mac_ctrl_t  mac_ctrl;
  logic [31:0] mac_power;
  logic       top_bin;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;
  assign rd_addr    = wp_q + i_q;
  assign top_bin    = (k_q == AddrW'(HalfPts));

  always_ff @(posedge clk_i) begin
    if (in_acc && mode == MODE_ADD) begin
      ring_mem[wp_q] <= sample_i;
    end
    rd_q <= ring_mem[rd_addr];
  end

  // datapath control per sequencer step
  always_comb begin
    mac_ctrl.dbl = (k_q != '0) && !top_bin;
    unique case (state_q)
      ST_BIN:   mac_ctrl.op = OP_CLR;
      ST_WIN:   mac_ctrl.op = OP_WIN;
      ST_COS:   mac_ctrl.op = OP_COS;
      ST_SIN:   mac_ctrl.op = OP_SIN;
      ST_ACC:   mac_ctrl.op = OP_ACC;
      ST_MAG:   mac_ctrl.op = OP_MAG;
      ST_SQR_R: mac_ctrl.op = OP_SQR_R;
      ST_SQR_I: mac_ctrl.op = OP_SQR_I;
      ST_SUM:   mac_ctrl.op = OP_SUM;
      default:  mac_ctrl.op = OP_NOP;
    endcase
  end

  shps_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (rd_q),
    .hann_i   (HannTab[i_q]),
    .twc_i    (CosTab[idx_q]),
    .tws_i    (SinTab[idx_q]),
    .power_o  (mac_power)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      i_q         <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      nr_q        <= 1'b0;
      out_valid_q <= 1'b0;
      bin_q       <= '0;
      power_q     <= '0;
      rdy_res_q   <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      // a new item loads in the same cycle the old one drains
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (mode)
              MODE_ADD: begin
                wp_q <= wp_q + 1'b1;
                if (fill_q != CntW'(Points)) fill_q <= fill_q + 1'b1;
              end
              MODE_CLEAR: begin
                wp_q   <= '0;
                fill_q <= '0;
              end
              MODE_SPEC: begin
                k_q <= '0;
                if (fill_q != CntW'(Points)) begin
                  nr_q    <= 1'b1;
                  state_q <= ST_EMIT;
                end else begin
                  nr_q    <= 1'b0;
                  state_q <= ST_BIN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_BIN: begin
          i_q     <= '0;
          idx_q   <= '0;
          state_q <= ST_RD;
        end
        ST_RD:  state_q <= ST_WIN;
        ST_WIN: state_q <= ST_COS;
        ST_COS: state_q <= ST_SIN;
        ST_SIN: state_q <= ST_ACC;
        ST_ACC: begin
          i_q   <= i_q + 1'b1;
          idx_q <= idx_q + k_q;
          state_q <= (i_q == AddrW'(Points - 1)) ? ST_MAG : ST_RD;
        end
        ST_MAG:   state_q <= ST_SQR_R;
        ST_SQR_R: state_q <= ST_SQR_I;
        ST_SQR_I: state_q <= ST_SUM;
        ST_SUM:   state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            if (nr_q) begin
              bin_q     <= '0;
              power_q   <= '0;
              rdy_res_q <= 1'b0;
              last_q    <= 1'b1;
              state_q   <= ST_IDLE;
            end else begin
              bin_q     <= k_q;
              power_q   <= mac_power;
              rdy_res_q <= 1'b1;
              last_q    <= top_bin;
              if (top_bin) begin
                state_q <= ST_IDLE;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= ST_BIN;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_o       = bin_q;
  assign power_o     = power_q;
  assign ready_res_o = rdy_res_q;
  assign last_o      = last_q;

  `SHPS_ASSERT_NEXT(a_spec_goes_busy, in_acc && mode_i == MODE_SPEC, !in_ready_o)
  `SHPS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CntW'(Points))
  `SHPS_ASSERT_NOW(a_not_ready_item, out_valid_o && !ready_res_o,
                   last_o && bin_o == '0 && power_o == '0)
  `SHPS_ASSERT_NOW(a_last_is_top, out_valid_o && ready_res_o && last_o,
                   bin_o == 6'(HalfPts))

endmodule
